/* hdl/pat_pkg.sv */
// Shared types and constants of the positional array table.
`timescale 1ns / 1ps

package pat_pkg;

  // Table geometry.
  localparam int DEPTH   = 128;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 8;
  localparam int COUNT_W = 8;
  localparam int DATA_W  = 32;
  // Width in which positions, pointers and the fill count are compared.
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_SEARCH = 2'd3
  } op_e;

  // One command item.
  typedef struct packed {
    op_e                      opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } pat_in_t;

  // One result item.
  typedef struct packed {
    logic [COUNT_W-1:0]       count;
    logic                     status;
    logic                     found;
    logic signed [DATA_W-1:0] read_value;
  } pat_out_t;

  // Request from the sequencer to the entry memory.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  // Finished result handed from the sequencer to the output stage.
  typedef struct packed {
    logic     valid;
    pat_out_t res;
  } fin_t;

endpackage

/* hdl/positional_array_table.sv */
// Top level of the positional array table: sequencer, entry memory, result register.
`timescale 1ns / 1ps

// Usage:
// A command item on cmd_i (opcode, position, value) is accepted at a rising
// edge where start_i is high and busy_o is low. One item is worked at a time.
// Each item gives exactly one result on res_o (count, status, found,
// read_value), marked by done_o for exactly one cycle; the receiver cannot
// stall, so it must take the result in that cycle.
// A rejected item goes straight to the finish state. Otherwise the sequencer
// walks the entry memory: a read fetches the entry at the position, a search
// compares every filled entry with the value, and an insert or delete shifts
// the entries between the position and the fill count by one place. A full
// table holds 128 entries. The entry memory has a single read port, so the
// sequencer moves or compares one entry per cycle.
// busy_o drops in the cycle that done_o rises, so a new item may be accepted
// while the result is shown.
// Reset clears the fill count and the sequencer; the entry memory is not
// cleared, as only entries below the fill count are ever read out.

module positional_array_table
  import pat_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  pat_in_t  cmd_i,
  output logic     busy_o,
  output logic     done_o,
  output pat_out_t res_o
);

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;
  fin_t              fin;
  logic              done_q;
  pat_out_t          res_q;

  pat_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .busy_o  (busy_o),
    .req_o   (ram_req),
    .rdata_i (ram_rdata),
    .fin_o   (fin)
  );

  pat_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin.valid;
    end
  end

  // Result payload, captured when an operation finishes.
  always_ff @(posedge clk_i) begin
    if (fin.valid) begin
      res_q <= fin.res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* hdl/pat_ram.sv */
// Entry memory: one write port and one registered read port.
`timescale 1ns / 1ps

module pat_ram
  import pat_pkg::*;
(
  input  logic              clk_i,
  input  ram_req_t          req_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/pat_seq.sv */
// Sequencer: checks each command, walks the memory and keeps the fill count.
`timescale 1ns / 1ps

module pat_seq
  import pat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  pat_in_t           cmd_i,
  output logic              busy_o,
  output ram_req_t          req_o,
  input  logic [DATA_W-1:0] rdata_i,
  output fin_t              fin_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CMP_W-1:0]  ptr_q, ptr_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  paddr_q, paddr_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              rej_q, rej_d;
  logic              found_q, found_d;
  logic [DATA_W-1:0] rd_q, rd_d;

  logic [CMP_W-1:0]  fill_ext, fill_next_ext, pos_ext, pos_in_ext;
  logic [CMP_W-1:0]  step_raddr, ptr_next;
  logic              more;

  assign fill_ext      = CMP_W'(fill_q);
  assign fill_next_ext = CMP_W'(fill_d);
  assign pos_ext       = CMP_W'(pos_q);
  assign pos_in_ext    = CMP_W'(cmd_i.position);
  assign busy_o        = (state_q != ST_IDLE);

  // Per-operation walk: whether another entry must be read, and where.
  always_comb begin
    more       = 1'b0;
    step_raddr = ptr_q;
    ptr_next   = ptr_q + CMP_W'(1);
    unique case (op_q)
      OP_INSERT: begin
        more       = (ptr_q > pos_ext);
        step_raddr = ptr_q - CMP_W'(1);
        ptr_next   = ptr_q - CMP_W'(1);
      end
      OP_DELETE: begin
        more       = ((ptr_q + CMP_W'(1)) < fill_ext);
        step_raddr = ptr_q + CMP_W'(1);
      end
      OP_READ: begin
        more = (ptr_q == pos_ext);
      end
      OP_SEARCH: begin
        more = (ptr_q < fill_ext);
      end
      default: begin
        more = 1'b0;
      end
    endcase
  end

  // Next state, memory requests and the finished result.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pos_d       = pos_q;
    val_d       = val_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    paddr_d     = paddr_q;
    fill_d      = fill_q;
    rej_d       = rej_q;
    found_d     = found_q;
    rd_d        = rd_q;
    req_o       = '0;
    fin_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d    = cmd_i.opcode;
          pos_d   = cmd_i.position;
          val_d   = cmd_i.value;
          pend_d  = 1'b0;
          found_d = 1'b0;
          rd_d    = '0;
          ptr_d   = pos_in_ext;
          rej_d   = (pos_in_ext >= fill_ext);
          case (cmd_i.opcode)
            OP_INSERT: begin
              ptr_d = fill_ext;
              rej_d = (pos_in_ext > fill_ext) || (fill_ext >= CMP_W'(DEPTH));
            end
            OP_SEARCH: begin
              ptr_d = '0;
              rej_d = 1'b0;
            end
            default: begin
            end
          endcase
          state_d = rej_d ? ST_FINISH : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Consume the entry read in the previous cycle.
        if (pend_q) begin
          case (op_q) inside
            OP_INSERT, OP_DELETE: begin
              req_o.we    = 1'b1;
              req_o.waddr = paddr_q;
              req_o.wdata = rdata_i;
            end
            OP_SEARCH: begin
              if (rdata_i == val_q) begin
                found_d = 1'b1;
              end
            end
            default: begin
              rd_d = rdata_i;
            end
          endcase
        end
        // Issue the next read; its target never equals the write address.
        if (more) begin
          req_o.re    = 1'b1;
          req_o.raddr = step_raddr[IDX_W-1:0];
          paddr_d     = ptr_q[IDX_W-1:0];
          ptr_d       = ptr_next;
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (!rej_q) begin
          case (op_q)
            OP_INSERT: begin
              req_o.we    = 1'b1;
              req_o.waddr = pos_ext[IDX_W-1:0];
              req_o.wdata = val_q;
              fill_d      = fill_q + CNT_W'(1);
            end
            OP_DELETE: begin
              fill_d = fill_q - CNT_W'(1);
            end
            default: begin
            end
          endcase
        end
        fin_o.valid          = 1'b1;
        fin_o.res.count      = fill_next_ext[COUNT_W-1:0];
        fin_o.res.status     = rej_q;
        fin_o.res.found      = found_q;
        fin_o.res.read_value = rd_q;
        state_d              = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
    end
  end

  // Command and working registers.
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    ptr_q   <= ptr_d;
    paddr_q <= paddr_d;
    rej_q   <= rej_d;
    found_q <= found_d;
    rd_q    <= rd_d;
  end

`ifndef SYNTHESIS
  // The fill count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(DEPTH))
    else $error("fill count exceeds depth");

  // The fill count moves only at the end of an operation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(fill_q) |-> $past(state_q) == ST_FINISH)
    else $error("fill count changed outside finish");

  // The memory is written only while an operation is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.we |-> state_q != ST_IDLE)
    else $error("memory write while idle");

  // An accepted item always takes the sequencer out of idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == ST_IDLE) |=> state_q != ST_IDLE)
    else $error("accepted item was dropped");
`endif

endmodule
